// File: rtl/plr_pkg.sv
// shared types and constants of the polyphase linear resampler
package plr_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 18;
	localparam int INDEX_W     = 8;
	localparam int STEP_CFG_W  = 22;
	localparam int FRAC_W      = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_RESULTS = 4;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	localparam logic [STEP_CFG_W-1:0] TIME_STEP_RESET = 22'd1048576;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum logic {
		KIND_SAMPLE,
		KIND_COEF
	} plr_kind_t;

	typedef struct packed {
		plr_kind_t                   kind;
		logic signed [SAMPLE_W-1:0]  sample;
		logic [INDEX_W-1:0]          coef_index;
		logic signed [COEF_W-1:0]    coef_value;
	} plr_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MAC,
		ST_DRAIN,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_EMIT
	} plr_state_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} plr_back_stat_t;

endpackage

// File: rtl/polyphase_linear_resampler.sv
// Arbitrary-ratio resampler: each sample item yields zero to four output items, each the
// linear blend of two adjacent polyphase FIR outputs, saturated to 16 bits. A coefficient
// load (tuser = 1) is written from the idle state and leaves the back end idle; for a sample
// item the back-end time is set by the dual multiply-accumulate that walks the taps one
// per cycle and the shared interpolation multiplier. A four-entry queue behind the input
// register absorbs bursts, and the output register lets the back end finish the next
// result while one waits. Coefficients must be loaded before samples that use them;
// time_step must be changed only while the block is idle; the block does not enforce it.
module polyphase_linear_resampler #(
	parameter int PHASES = 16,
	parameter int TAPS   = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	// time_step [21:0]
	input  logic [plr_pkg::STEP_CFG_W-1:0]      cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// sample_in [15:0], coef_index [23:16], coef_value [41:24], zero [47:42]
	input  logic [plr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// cmd [0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// sample_out [15:0]
	output logic [plr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast
);

	logic [plr_pkg::STEP_CFG_W-1:0] time_step_q;
	logic                           f_valid;
	logic                           f_ready;
	plr_pkg::plr_entry_t            f_data;
	logic                           q_valid;
	logic                           q_ready;
	plr_pkg::plr_entry_t            q_data;
	plr_pkg::plr_back_stat_t        bstat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= plr_pkg::TIME_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			time_step_q <= cfg_data;
		end
	end

	plr_front #(
		.NCOEF(PHASES * TAPS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_valid      (f_valid),
		.q_ready      (f_ready),
		.q_data       (f_data)
	);

	plr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_data)
	);

	plr_back #(
		.PHASES(PHASES),
		.TAPS  (TAPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_step    (time_step_q),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_data       (q_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.stat         (bstat)
	);

`ifndef SYNTHESIS
	// the back end only leaves idle after taking a queued item
	a_leave_idle_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bstat.idle) |-> $past(q_valid))
		else $error("back end started without a queued item");

	// a coefficient load never starts a computation
	a_coef_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop && (q_data.kind == plr_pkg::KIND_COEF) |=> bstat.idle)
		else $error("coefficient item left the back end busy");

	// a waiting result without tlast means more results of that sample are coming
	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !bstat.idle)
		else $error("back end idle while its result run is still open");
`endif

endmodule

// File: rtl/plr_front.sv
// input stage: takes items, decodes them and drops out-of-range coefficient writes
module plr_front #(
	parameter int unsigned NCOEF = 192
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// sample_in [15:0], coef_index [23:16], coef_value [41:24], zero [47:42]
	input  logic [plr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// cmd [0]
	input  logic                                s_axis_tuser,
	output logic                                q_valid,
	input  logic                                q_ready,
	output plr_pkg::plr_entry_t                 q_data
);

	plr_pkg::plr_entry_t dec;
	plr_pkg::plr_entry_t entry_q;
	logic                keep;
	logic                valid_q;
	logic                s_fire;

	always_comb begin
		dec.kind       = (s_axis_tuser == plr_pkg::CMD_COEF) ? plr_pkg::KIND_COEF
		                                                     : plr_pkg::KIND_SAMPLE;
		dec.sample     = s_axis_tdata[15:0];
		dec.coef_index = s_axis_tdata[23:16];
		dec.coef_value = s_axis_tdata[41:24];
	end

	// a coefficient write beyond the table is swallowed here
	assign keep = (dec.kind == plr_pkg::KIND_SAMPLE) || (32'(dec.coef_index) < NCOEF);

	assign s_axis_tready = !valid_q || q_ready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_fire) begin
			valid_q <= keep;
		end else if (q_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			entry_q <= dec;
		end
	end

	assign q_valid = valid_q;
	assign q_data  = entry_q;

endmodule

// File: rtl/plr_queue.sv
// short item queue between the front end and the compute back end
module plr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  plr_pkg::plr_entry_t  push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output plr_pkg::plr_entry_t  pop_data
);

	localparam int PTR_W = $clog2(plr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(plr_pkg::QUEUE_DEPTH + 1);

	plr_pkg::plr_entry_t mem_q [plr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push_fire;
	logic                pop_fire;

	assign push_ready = (count_q != CNT_W'(plr_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(plr_pkg::QUEUE_DEPTH - 1)) ? '0
				                                                         : wr_ptr_q + PTR_W'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(plr_pkg::QUEUE_DEPTH - 1)) ? '0
				                                                         : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_fire) - CNT_W'(pop_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/plr_back.sv
// compute back end: history, coefficient memory, dual mac, interpolation and output register
module plr_back #(
	parameter int PHASES = 16,
	parameter int TAPS   = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [plr_pkg::STEP_CFG_W-1:0]          time_step,
	input  logic                                    q_valid,
	output logic                                    q_ready,
	input  plr_pkg::plr_entry_t                     q_data,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [plr_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	output logic                                    m_axis_tlast,
	output plr_pkg::plr_back_stat_t                 stat
);

	localparam int NCOEF  = PHASES * TAPS;
	localparam int CA_W   = $clog2(NCOEF);
	localparam int PW     = $clog2(PHASES);
	localparam int CW     = $clog2(TAPS);
	localparam int NW     = $clog2(plr_pkg::MAX_RESULTS + 1);
	localparam int STEP_W = ($clog2(PHASES) + 15 > plr_pkg::STEP_CFG_W) ? $clog2(PHASES) + 15
	                                                                   : plr_pkg::STEP_CFG_W;
	localparam longint unsigned SPAN     = longint'(PHASES) << plr_pkg::FRAC_W;
	localparam longint unsigned MIN_STEP = longint'(PHASES) << 14;
	localparam int RW     = $clog2(SPAN + (longint'(1) << STEP_W));
	localparam int PROD_W = plr_pkg::SAMPLE_W + plr_pkg::COEF_W;
	localparam int AW     = PROD_W + $clog2(TAPS);
	localparam int DW     = AW + 1;
	localparam int DLO    = DW / 2;
	localparam int DHI    = DW - DLO;
	localparam int MA     = DHI + 1;
	localparam int MB     = plr_pkg::FRAC_W + 1;
	localparam int MP     = MA + MB;
	localparam int SW     = AW + 18;
	localparam logic signed [SW-1:0] RND_HALF = SW'(64'd1 << 32);

	plr_pkg::plr_state_t state_q, state_d;

	logic signed [plr_pkg::SAMPLE_W-1:0] hist_q [TAPS+1];
	logic signed [plr_pkg::SAMPLE_W-1:0] work_q [TAPS+1];
	logic signed [plr_pkg::COEF_W-1:0]   coef_mem [NCOEF];

	logic [RW-1:0]     rel_q;
	logic [RW-1:0]     rel_next_q;
	logic [NW-1:0]     n_q;
	logic [CW-1:0]     cnt_q;
	logic [CA_W-1:0]   addr1_q;
	logic [CA_W-1:0]   addr2_q;
	logic              wrap_q;

	logic signed [plr_pkg::COEF_W-1:0]   rd1_s1, rd2_s1;
	logic signed [plr_pkg::SAMPLE_W-1:0] x1_s1, x2_s1;
	logic                                v_s1;
	logic signed [PROD_W-1:0]            prod1_s2, prod2_s2;
	logic                                v_s2;
	logic signed [AW-1:0]                acc1_q, acc2_q;
	logic signed [DW-1:0]                d_q;
	logic signed [MP-1:0]                p_q;
	logic signed [SW-1:0]                sum_q;

	logic                                out_valid_q;
	logic [plr_pkg::OUT_TDATA_W-1:0]     out_data_q;
	logic                                out_last_q;

	logic [PW-1:0]                 phase;
	logic [plr_pkg::FRAC_W-1:0]    frac;
	logic [STEP_W-1:0]             step_ext;
	logic [STEP_W-1:0]             step_eff;
	logic                          more;
	logic                          out_free;
	logic                          drain_done;
	logic                          mac_last;
	logic                          is_sample;
	logic                          last_res;

	logic signed [MA-1:0]          mul_a;
	logic signed [MB-1:0]          mul_b;
	logic signed [MP-1:0]          mul_p;
	logic signed [SW-1:0]          rnd;
	logic signed [SW-1:0]          yw;
	logic signed [plr_pkg::SAMPLE_W-1:0] ysat;

	logic pop, hist_shift, coef_wr, setup_go, setup_end, issue;
	logic diff_go, mul_lo, mul_hi, sum_go, emit;

	assign phase      = rel_q[plr_pkg::FRAC_W +: PW];
	assign frac       = rel_q[plr_pkg::FRAC_W-1:0];
	assign step_ext   = STEP_W'(time_step);
	assign step_eff   = (step_ext < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : step_ext;
	assign more       = (rel_q < RW'(SPAN)) && (n_q < NW'(plr_pkg::MAX_RESULTS));
	assign out_free   = !out_valid_q || m_axis_tready;
	assign drain_done = !v_s1 && !v_s2;
	assign mac_last   = (cnt_q == CW'(TAPS - 1));
	assign is_sample  = (q_data.kind == plr_pkg::KIND_SAMPLE);
	assign last_res   = !((rel_next_q < RW'(SPAN)) && (n_q < NW'(plr_pkg::MAX_RESULTS - 1)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			plr_pkg::ST_IDLE: begin
				if (q_valid && is_sample) state_d = plr_pkg::ST_SETUP;
			end
			plr_pkg::ST_SETUP: begin
				state_d = more ? plr_pkg::ST_MAC : plr_pkg::ST_IDLE;
			end
			plr_pkg::ST_MAC: begin
				if (mac_last) state_d = plr_pkg::ST_DRAIN;
			end
			plr_pkg::ST_DRAIN: begin
				if (drain_done) state_d = plr_pkg::ST_DIFF;
			end
			plr_pkg::ST_DIFF:   state_d = plr_pkg::ST_MUL_LO;
			plr_pkg::ST_MUL_LO: state_d = plr_pkg::ST_MUL_HI;
			plr_pkg::ST_MUL_HI: state_d = plr_pkg::ST_SUM;
			plr_pkg::ST_SUM:    state_d = plr_pkg::ST_EMIT;
			plr_pkg::ST_EMIT: begin
				if (out_free) state_d = plr_pkg::ST_SETUP;
			end
			default: state_d = plr_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_ready    = 1'b0;
		pop        = 1'b0;
		hist_shift = 1'b0;
		coef_wr    = 1'b0;
		setup_go   = 1'b0;
		setup_end  = 1'b0;
		issue      = 1'b0;
		diff_go    = 1'b0;
		mul_lo     = 1'b0;
		mul_hi     = 1'b0;
		sum_go     = 1'b0;
		emit       = 1'b0;
		case (state_q)
			plr_pkg::ST_IDLE: begin
				q_ready    = 1'b1;
				pop        = q_valid;
				hist_shift = q_valid && is_sample;
				coef_wr    = q_valid && !is_sample;
			end
			plr_pkg::ST_SETUP: begin
				setup_go  = more;
				setup_end = !more;
			end
			plr_pkg::ST_MAC:    issue   = 1'b1;
			plr_pkg::ST_DRAIN:  ;
			plr_pkg::ST_DIFF:   diff_go = 1'b1;
			plr_pkg::ST_MUL_LO: mul_lo  = 1'b1;
			plr_pkg::ST_MUL_HI: mul_hi  = 1'b1;
			plr_pkg::ST_SUM:    sum_go  = 1'b1;
			plr_pkg::ST_EMIT:   emit    = out_free;
			default: ;
		endcase
	end

	assign stat.idle = (state_q == plr_pkg::ST_IDLE);
	assign stat.pop  = pop;

	// shared multiplier for the two halves of the difference times the fraction
	always_comb begin
		if (mul_hi) begin
			mul_a = MA'(signed'(d_q[DW-1:DLO]));
		end else begin
			mul_a = signed'(MA'({1'b0, d_q[DLO-1:0]}));
		end
		mul_b = signed'({1'b0, frac});
		mul_p = mul_a * mul_b;
	end

	// round half up, then clamp to the sample range
	always_comb begin
		rnd = sum_q + RND_HALF;
		yw  = rnd >>> 33;
		if ((&yw[SW-1:plr_pkg::SAMPLE_W-1]) || !(|yw[SW-1:plr_pkg::SAMPLE_W-1])) begin
			ysat = yw[plr_pkg::SAMPLE_W-1:0];
		end else begin
			ysat = yw[SW-1] ? plr_pkg::SAMPLE_MIN : plr_pkg::SAMPLE_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plr_pkg::ST_IDLE;
			rel_q       <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k <= TAPS; k++) begin
				hist_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (hist_shift) begin
				for (int k = 0; k < TAPS; k++) begin
					hist_q[k] <= hist_q[k+1];
				end
				hist_q[TAPS] <= q_data.sample;
				n_q          <= '0;
			end else if (emit) begin
				n_q <= n_q + NW'(1);
			end
			if (setup_end) begin
				rel_q <= rel_q - RW'(SPAN);
			end else if (emit) begin
				rel_q <= rel_next_q;
			end
			if (setup_go) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// coefficient memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (coef_wr) begin
			coef_mem[CA_W'(q_data.coef_index)] <= q_data.coef_value;
		end
		rd1_s1 <= coef_mem[addr1_q];
		rd2_s1 <= coef_mem[addr2_q];
	end

	always_ff @(posedge clk) begin
		if (setup_go) begin
			for (int k = 0; k <= TAPS; k++) begin
				work_q[k] <= hist_q[k];
			end
			addr1_q <= CA_W'(int'(phase) * TAPS);
			// the last phase pairs with phase zero one sample later
			addr2_q <= (phase == PW'(PHASES - 1)) ? '0 : CA_W'((int'(phase) + 1) * TAPS);
			wrap_q  <= (phase == PW'(PHASES - 1));
			acc1_q  <= '0;
			acc2_q  <= '0;
		end else begin
			if (issue) begin
				for (int k = 1; k <= TAPS; k++) begin
					work_q[k] <= work_q[k-1];
				end
				work_q[0] <= '0;
				addr1_q   <= addr1_q + CA_W'(1);
				addr2_q   <= addr2_q + CA_W'(1);
			end
			if (v_s2) begin
				acc1_q <= acc1_q + AW'(prod1_s2);
				acc2_q <= acc2_q + AW'(prod2_s2);
			end
		end
		x1_s1    <= work_q[TAPS-1];
		x2_s1    <= wrap_q ? work_q[TAPS] : work_q[TAPS-1];
		prod1_s2 <= rd1_s1 * x1_s1;
		prod2_s2 <= rd2_s1 * x2_s1;
		if (diff_go) begin
			d_q <= DW'(acc2_q) - DW'(acc1_q);
		end
		if (mul_lo || mul_hi) begin
			p_q <= mul_p;
		end
		if (mul_hi) begin
			sum_q <= (SW'(acc1_q) <<< plr_pkg::FRAC_W) + SW'(p_q);
		end else if (sum_go) begin
			sum_q      <= sum_q + (SW'(p_q) <<< DLO);
			rel_next_q <= rel_q + RW'(step_eff);
		end
		if (emit) begin
			out_data_q <= ysat;
			out_last_q <= last_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule
